// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/stunbrp_pkg.sv =====
// ---------------------------------------------------------------------------
// stunbrp_pkg
// Constants and field layout for the STUN binding response parser.
// ---------------------------------------------------------------------------
package stunbrp_pkg;

   // Header layout
   localparam int unsigned HDR_LEN      = 20;
   localparam logic [31:0] MAGIC_COOKIE = 32'h2112_A442;
   localparam logic [7:0]  TYPE_HI_BYTE = 8'h01;
   localparam logic [7:0]  TYPE_LO_OK   = 8'h01;
   localparam logic [7:0]  TYPE_LO_ERR  = 8'h11;

   // Attributes
   localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
   localparam logic [15:0] ATTR_REQUIRED_MAX = 16'h7fff;
   localparam logic [15:0] PORT_XOR_KEY     = 16'h2112;
   localparam logic [7:0]  FAMILY_IPV4      = 8'h01;
   localparam logic [7:0]  FAMILY_IPV6      = 8'h02;
   localparam logic [15:0] LEN_IPV4_ATTR    = 16'd8;
   localparam logic [15:0] LEN_IPV6_ATTR    = 16'd20;

   // Address kind codes
   localparam logic [1:0] ADDR_KIND_NONE = 2'd0;
   localparam logic [1:0] ADDR_KIND_IPV4 = 2'd1;
   localparam logic [1:0] ADDR_KIND_IPV6 = 2'd2;
   localparam logic [1:0] ADDR_KIND_BAD  = 2'd3;

   // Configuration register indexes
   localparam logic CSR_TXID_HIGH = 1'b0;
   localparam logic CSR_TXID_LOW  = 1'b1;

   // Port widths
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 144;
   localparam int unsigned RSP_USER_W = 4;
   localparam int unsigned CSR_DATA_W = 64;

endpackage

// ===== hdl/stun_binding_response_parser.sv =====
// ---------------------------------------------------------------------------
// stun_binding_response_parser
// Byte-serial STUN binding response parser: header check, attribute walk,
// XOR-MAPPED-ADDRESS decode, one verdict per datagram.
// ---------------------------------------------------------------------------
//  Channel | Dir | Handshake         | Payload
//  req     | in  | tvalid/tready     | tdata[7:0] data byte, tlast last byte
//  rsp     | out | tvalid/tready     | tdata port/addr, tuser error/success/kind
//  csr     | in  | csr_valid/ready   | csr_index register, csr_data value
//
//  One byte per cycle unless refused; each byte updates the frame state in
//  the cycle it is taken, and a last byte's verdict is registered as the
//  result. Reset is synchronous and returns the frame state to the start of
//  a datagram and clears the transaction ID. A byte is refused only while a
//  verdict waits and rsp_tready is low; csr writes are always taken.
// ---------------------------------------------------------------------------
module stun_binding_response_parser (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: data_byte[7:0]
   input  logic [stunbrp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                   req_tlast,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata: mapped_port[15:0], addr_upper[79:16], addr_lower[143:80]
   output logic [stunbrp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: parse_error[0], is_success[1], addr_kind[3:2]
   output logic [stunbrp_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic                                   csr_index,
   input  logic [stunbrp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import stunbrp_pkg::*;

   // Configuration
   logic [31:0] txid_high_ff;
   logic [63:0] txid_low_ff;

   // Frame state
   logic [16:0]      pos_ff,        pos_in;
   logic [7:0]       len_hi_ff,     len_hi_in;
   logic [15:0]      body_len_ff,   body_len_in;
   logic             good_ff,       good_in;
   logic             success_ff,    success_in;
   logic [16:0]      next_start_ff, next_start_in;
   logic [15:0]      atype_ff,      atype_in;
   logic [15:0]      alen_ff,       alen_in;
   logic             stopped_ff,    stopped_in;
   logic             error_ff,      error_in;
   logic             found_ff,      found_in;
   logic [7:0]       family_ff,     family_in;
   logic [15:0]      port_ff,       port_in;
   logic [7:0][7:0]  addr_hi_ff,    addr_hi_in;
   logic [7:0][7:0]  addr_lo_ff,    addr_lo_in;
   logic [1:0]       kind_ff,       kind_in;

   // Result register
   logic             rsp_valid_ff,  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic             req_fire;
   logic [15:0][7:0] key_bytes;
   logic [7:0]       b;
   logic [16:0]      end_pos;
   logic [16:0]      rel;
   logic [3:0]       k;
   logic             fail;
   logic             xma;
   logic [17:0]      attr_end;
   logic [17:0]      size;
   logic [17:0]      end_new;
   logic             ok;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Cookie followed by transaction ID, byte 0 in the top lane
   assign key_bytes = {MAGIC_COOKIE, txid_high_ff, txid_low_ff};
   assign b         = req_tdata[7:0];
   assign end_pos   = 17'(HDR_LEN) + 17'(body_len_ff);
   assign rel       = pos_ff - next_start_ff;
   assign k         = 4'(rel - 17'd8);
   assign xma       = success_ff && (atype_ff == ATTR_XOR_MAPPED);

   // Per-byte frame update and verdict
   always_comb begin
      pos_in        = pos_ff;
      len_hi_in     = len_hi_ff;
      body_len_in   = body_len_ff;
      good_in       = good_ff;
      success_in    = success_ff;
      next_start_in = next_start_ff;
      atype_in      = atype_ff;
      alen_in       = alen_ff;
      stopped_in    = stopped_ff;
      error_in      = error_ff;
      found_in      = found_ff;
      family_in     = family_ff;
      port_in       = port_ff;
      addr_hi_in    = addr_hi_ff;
      addr_lo_in    = addr_lo_ff;
      kind_in       = kind_ff;
      fail          = 1'b0;
      attr_end      = 18'(next_start_ff) + 18'd4 + 18'(alen_ff);

      if (req_fire) begin
         if (pos_ff < 17'(HDR_LEN)) begin
            // Header bytes
            priority if (pos_ff == 17'd0) begin
               good_in = good_ff && (b == TYPE_HI_BYTE);
            end else if (pos_ff == 17'd1) begin
               good_in    = good_ff && (b == TYPE_LO_OK || b == TYPE_LO_ERR);
               success_in = (b == TYPE_LO_OK);
            end else if (pos_ff == 17'd2) begin
               len_hi_in = b;
            end else if (pos_ff == 17'd3) begin
               body_len_in = {len_hi_ff, b};
            end else begin
               // cookie and transaction ID
               good_in = good_ff && (b == key_bytes[~(4'(pos_ff - 17'd4))]);
            end
         end else if (!stopped_ff && pos_ff < end_pos && pos_ff >= next_start_ff) begin
            // Attribute walk
            priority if (rel == 17'd0) begin
               if (end_pos - pos_ff < 17'd4) fail = 1'b1;
               else atype_in = {b, 8'h00};
            end else if (rel == 17'd1) begin
               atype_in = {atype_ff[15:8], b};
            end else if (rel == 17'd2) begin
               alen_in = {b, 8'h00};
            end else if (rel == 17'd3) begin
               alen_in  = {alen_ff[15:8], b};
               attr_end = 18'(next_start_ff) + 18'd4 + 18'(alen_in);
               if ({1'b0, end_pos} < attr_end) fail = 1'b1;
               else if (xma) begin
                  if (alen_in < 16'd4) fail = 1'b1;
               end else if (atype_ff <= ATTR_REQUIRED_MAX) begin
                  fail = 1'b1;
               end
            end else if (xma) begin
               priority if (rel == 17'd5) begin
                  family_in = b;
               end else if (rel == 17'd6) begin
                  if (!found_ff) port_in = {b, 8'h00};
               end else if (rel == 17'd7) begin
                  if (!found_ff) port_in = {port_ff[15:8], b} ^ PORT_XOR_KEY;
                  if ((family_ff == FAMILY_IPV4 && alen_ff != LEN_IPV4_ATTR) ||
                      (family_ff == FAMILY_IPV6 && alen_ff != LEN_IPV6_ATTR))
                     fail = 1'b1;
               end else if (rel >= 17'd8 && !found_ff) begin
                  if (family_ff == FAMILY_IPV4 && rel < 17'd12) begin
                     addr_lo_in[{1'b0, ~k[1:0]}] = addr_lo_ff[{1'b0, ~k[1:0]}] |
                                                   (b ^ key_bytes[~k]);
                     if (k == 4'd3) begin
                        found_in = 1'b1;
                        kind_in  = ADDR_KIND_IPV4;
                     end
                  end else if (family_ff == FAMILY_IPV6 && rel < 17'd24) begin
                     if (!k[3])
                        addr_hi_in[~k[2:0]] = addr_hi_ff[~k[2:0]] | (b ^ key_bytes[~k]);
                     else
                        addr_lo_in[~k[2:0]] = addr_lo_ff[~k[2:0]] | (b ^ key_bytes[~k]);
                     if (k == 4'd15) begin
                        found_in = 1'b1;
                        kind_in  = ADDR_KIND_IPV6;
                     end
                  end
               end else begin
                  // attribute value byte with nothing to keep
               end
            end else begin
               // value byte of a skipped attribute
            end

            if (fail) begin
               stopped_in = 1'b1;
               error_in   = 1'b1;
            end else if (rel >= 17'd3 && rel == 17'(alen_in) + 17'd3) begin
               next_start_in = 17'(attr_end);
            end
         end

         if (pos_ff != 17'h1FFFF) pos_in = pos_ff + 17'd1;
      end

      // Verdict from the updated state
      size    = 18'(pos_ff) + 18'd1;
      end_new = 18'(HDR_LEN) + 18'(body_len_in);
      ok      = (size >= 18'(HDR_LEN)) && good_in && (body_len_in[1:0] == 2'b00) &&
                (size >= end_new);

      rsp_data_in = '0;
      rsp_user_in = {ADDR_KIND_NONE, 1'b0, 1'b1};
      if (ok) begin
         rsp_user_in[0] = error_in || (success_in && !found_in);
         rsp_user_in[1] = success_in;
         if (found_in) begin
            rsp_user_in[3:2] = kind_in;
            rsp_data_in      = {addr_lo_in, addr_hi_in, port_in};
         end
      end

      // Start a new datagram after the verdict
      if (req_fire && req_tlast) begin
         pos_in        = '0;
         len_hi_in     = '0;
         body_len_in   = '0;
         good_in       = 1'b1;
         success_in    = 1'b0;
         next_start_in = 17'(HDR_LEN);
         atype_in      = '0;
         alen_in       = '0;
         stopped_in    = 1'b0;
         error_in      = 1'b0;
         found_in      = 1'b0;
         family_in     = '0;
         port_in       = '0;
         addr_hi_in    = '0;
         addr_lo_in    = '0;
         kind_in       = ADDR_KIND_NONE;
      end
   end

   // Result valid: set by a last byte, cleared when taken
   always_comb begin
      if (req_fire && req_tlast) rsp_valid_in = 1'b1;
      else if (rsp_tready)       rsp_valid_in = 1'b0;
      else                       rsp_valid_in = rsp_valid_ff;
   end

   // Frame state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         len_hi_ff     <= '0;
         body_len_ff   <= '0;
         good_ff       <= 1'b1;
         success_ff    <= 1'b0;
         next_start_ff <= 17'(HDR_LEN);
         atype_ff      <= '0;
         alen_ff       <= '0;
         stopped_ff    <= 1'b0;
         error_ff      <= 1'b0;
         found_ff      <= 1'b0;
         family_ff     <= '0;
         port_ff       <= '0;
         addr_hi_ff    <= '0;
         addr_lo_ff    <= '0;
         kind_ff       <= ADDR_KIND_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         len_hi_ff     <= len_hi_in;
         body_len_ff   <= body_len_in;
         good_ff       <= good_in;
         success_ff    <= success_in;
         next_start_ff <= next_start_in;
         atype_ff      <= atype_in;
         alen_ff       <= alen_in;
         stopped_ff    <= stopped_in;
         error_ff      <= error_in;
         found_ff      <= found_in;
         family_ff     <= family_in;
         port_ff       <= port_in;
         addr_hi_ff    <= addr_hi_in;
         addr_lo_ff    <= addr_lo_in;
         kind_ff       <= kind_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_fire && req_tlast) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // Transaction ID registers
   always_ff @(posedge clock) begin
      if (reset) begin
         txid_high_ff <= '0;
         txid_low_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TXID_HIGH: txid_high_ff <= csr_data[31:0];
            CSR_TXID_LOW:  txid_low_ff  <= csr_data;
         endcase
      end
   end

endmodule

// ===== hdl/stunbrp_checker.sv =====
// ---------------------------------------------------------------------------
// stunbrp_checker
// Port-level checks for the STUN binding response parser.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stunbrp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tlast,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [stunbrp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [stunbrp_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready
);
   import stunbrp_pkg::*;

   logic last_fire;
   assign last_fire = req_tvalid && req_tready && req_tlast;

   // A waiting verdict is not dropped
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // Every last byte gives a verdict in the next cycle
   `CHK_NEXT(a_last_gives_rsp, clock, reset, last_fire, rsp_tvalid)

   // A verdict only follows a last byte
   `CHK_IMPLY(a_rsp_from_last, clock, reset, $rose(rsp_tvalid), $past(last_fire))

   // The kind code is never the unused value
   `CHK_IMPLY(a_kind_legal, clock, reset, rsp_tvalid, rsp_tuser[3:2] != ADDR_KIND_BAD)

   // Without an address, port and address are zero
   `CHK_IMPLY(a_no_addr_zero, clock, reset, rsp_tvalid && rsp_tuser[3:2] == ADDR_KIND_NONE, rsp_tdata == '0)

endmodule

bind stun_binding_response_parser stunbrp_checker u_stunbrp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tlast  (req_tlast),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
